// ===== rtl/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
`default_nettype none

package spq_pkg;

  // operation codes of an input transaction
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // status codes of a result transaction
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;  // insert the new entry, cells behind it move up
    logic deq;  // drop the head, every cell takes its upper neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue built as a chain of slot cells kept in ascending priority order.
// The result transaction of an accepted input transaction is registered and appears in the cycle after it.
// Throughput: one transaction per cycle while in_stall is low; every cell compares and shifts in the same cycle.
// A result waiting in the output register stalls the input only while out_stall is high.
// Synchronous active-low reset empties the queue and clears the output valid.
`default_nettype none

module sorted_priority_queue_top #(
  parameter int CAPACITY      = 16,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16,
  localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_op,
  input  wire        [PAYLOAD_BITS-1:0]    in_item_payload,
  input  wire signed [PRIORITY_BITS-1:0]   in_item_priority,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic       [1:0]                 out_status,
  output logic       [PAYLOAD_BITS-1:0]    out_payload,
  output logic signed [PRIORITY_BITS-1:0]  out_priority,
  output logic       [CNT_W-1:0]           out_entry_count,
  output logic                             out_is_empty,
  output logic       [PAYLOAD_BITS-1:0]    out_head_payload,
  output logic signed [PRIORITY_BITS-1:0]  out_head_priority,
  output logic       [PAYLOAD_BITS-1:0]    out_tail_payload,
  output logic signed [PRIORITY_BITS-1:0]  out_tail_priority
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic                             in_acc;
  logic                             enq_ok, deq_ok;
  spq_pkg::cell_ctrl_t              ctrl;
  spq_pkg::status_t                 status_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;

  logic        [PAYLOAD_BITS-1:0]   cell_pay [CAPACITY];
  logic signed [PRIORITY_BITS-1:0]  cell_pri [CAPACITY];
  logic        [CAPACITY-1:0]       cell_gt;

  logic        [PAYLOAD_BITS-1:0]   tail_pay_r, tail_pay_nxt;
  logic signed [PRIORITY_BITS-1:0]  tail_pri_r, tail_pri_nxt;
  logic        [PAYLOAD_BITS-1:0]   head_pay_nxt;
  logic signed [PRIORITY_BITS-1:0]  head_pri_nxt;

  logic                             out_valid_r, out_valid_nxt;
  spq_pkg::status_t                 status_r;
  logic        [PAYLOAD_BITS-1:0]   dq_pay_r, dq_pay_nxt;
  logic signed [PRIORITY_BITS-1:0]  dq_pri_r, dq_pri_nxt;
  logic        [CNT_W-1:0]          cnt_out_r;
  logic        [PAYLOAD_BITS-1:0]   head_pay_r;
  logic signed [PRIORITY_BITS-1:0]  head_pri_r;
  logic        [PAYLOAD_BITS-1:0]   tailo_pay_r;
  logic signed [PRIORITY_BITS-1:0]  tailo_pri_r;

  // handshake: take a transaction unless a held result is stalled
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // operation decode
  assign enq_ok = in_acc && (in_op == spq_pkg::OP_ENQUEUE) && (count_r != FULL_CNT);
  assign deq_ok = in_acc && (in_op == spq_pkg::OP_DEQUEUE) && (count_r != '0);
  assign ctrl.enq = enq_ok;
  assign ctrl.deq = deq_ok;

  always_comb begin
    status_nxt = spq_pkg::ST_OK;
    if (in_op == spq_pkg::OP_ENQUEUE) begin
      if (count_r == FULL_CNT) status_nxt = spq_pkg::ST_OVERFLOW;
    end else begin
      if (count_r == '0) status_nxt = spq_pkg::ST_UNDERFLOW;
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (enq_ok)      count_nxt = count_r + CNT_W'(1);
    else if (deq_ok) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // chain of slot cells, slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                             occ;
    logic                             gtp;
    logic        [PAYLOAD_BITS-1:0]   pp;
    logic signed [PRIORITY_BITS-1:0]  pq;
    logic        [PAYLOAD_BITS-1:0]   np;
    logic signed [PRIORITY_BITS-1:0]  nq;

    assign occ = count_r > CNT_W'(i);

    if (i == 0) begin : g_first
      assign gtp = 1'b0;
      assign pp  = in_item_payload;
      assign pq  = in_item_priority;
    end else begin : g_mid
      assign gtp = cell_gt[i-1];
      assign pp  = cell_pay[i-1];
      assign pq  = cell_pri[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign np = cell_pay[i];
      assign nq = cell_pri[i];
    end else begin : g_inner
      assign np = cell_pay[i+1];
      assign nq = cell_pri[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occ),
      .gt_prev  (gtp),
      .new_pay  (in_item_payload),
      .new_pri  (in_item_priority),
      .prev_pay (pp),
      .prev_pri (pq),
      .next_pay (np),
      .next_pri (nq),
      .gt       (cell_gt[i]),
      .q_pay    (cell_pay[i]),
      .q_pri    (cell_pri[i])
    );
  end

  // tail tracking: the new entry becomes the tail when nothing stored is larger
  always_comb begin
    tail_pay_nxt = tail_pay_r;
    tail_pri_nxt = tail_pri_r;
    if (enq_ok && ((count_r == '0) || (in_item_priority >= tail_pri_r))) begin
      tail_pay_nxt = in_item_payload;
      tail_pri_nxt = in_item_priority;
    end
  end

  always_ff @(posedge clk) begin
    tail_pay_r <= tail_pay_nxt;
    tail_pri_r <= tail_pri_nxt;
  end

  // head after this transaction
  always_comb begin
    head_pay_nxt = cell_pay[0];
    head_pri_nxt = cell_pri[0];
    if (enq_ok && cell_gt[0]) begin
      head_pay_nxt = in_item_payload;
      head_pri_nxt = in_item_priority;
    end else if (deq_ok) begin
      head_pay_nxt = cell_pay[1];
      head_pri_nxt = cell_pri[1];
    end
  end

  // dequeued entry
  always_comb begin
    dq_pay_nxt = '0;
    dq_pri_nxt = '0;
    if (deq_ok) begin
      dq_pay_nxt = cell_pay[0];
      dq_pri_nxt = cell_pri[0];
    end
  end

  // output register
  assign out_valid_nxt = in_acc ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r    <= status_nxt;
      dq_pay_r    <= dq_pay_nxt;
      dq_pri_r    <= dq_pri_nxt;
      cnt_out_r   <= count_nxt;
      head_pay_r  <= (count_nxt == '0) ? '0 : head_pay_nxt;
      head_pri_r  <= (count_nxt == '0) ? '0 : head_pri_nxt;
      tailo_pay_r <= (count_nxt == '0) ? '0 : tail_pay_nxt;
      tailo_pri_r <= (count_nxt == '0) ? '0 : tail_pri_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_payload       = dq_pay_r;
  assign out_priority      = dq_pri_r;
  assign out_entry_count   = cnt_out_r;
  assign out_is_empty      = (cnt_out_r == '0);
  assign out_head_payload  = head_pay_r;
  assign out_head_priority = head_pri_r;
  assign out_tail_payload  = tailo_pay_r;
  assign out_tail_priority = tailo_pri_r;

`ifndef SYNTHESIS
  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  // a dequeue on an empty queue reports underflow
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == spq_pkg::OP_DEQUEUE) && (count_r == '0))
      |=> (out_status == spq_pkg::ST_UNDERFLOW) && out_valid)
    else $error("empty dequeue without underflow status");

  // an enqueue on a full queue leaves the count unchanged
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == spq_pkg::OP_ENQUEUE) && (count_r == FULL_CNT))
      |=> (count_r == FULL_CNT) && (out_status == spq_pkg::ST_OVERFLOW))
    else $error("full enqueue changed the queue");

  // the two head slots stay in ascending order
  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_pri[0] <= cell_pri[1]))
    else $error("head slots out of order");

  // the reported count matches the live count after each transaction
  a_count_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_entry_count == count_r))
    else $error("result count differs from stored count");
`endif

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// one slot of the sorted chain: holds an entry and moves it to or from its neighbors
`default_nettype none

module spq_cell #(
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  wire                              clk,
  input  wire spq_pkg::cell_ctrl_t         ctrl,
  input  wire                              occupied,
  input  wire                              gt_prev,
  input  wire        [PAYLOAD_BITS-1:0]    new_pay,
  input  wire signed [PRIORITY_BITS-1:0]   new_pri,
  input  wire        [PAYLOAD_BITS-1:0]    prev_pay,
  input  wire signed [PRIORITY_BITS-1:0]   prev_pri,
  input  wire        [PAYLOAD_BITS-1:0]    next_pay,
  input  wire signed [PRIORITY_BITS-1:0]   next_pri,
  output logic                             gt,
  output logic       [PAYLOAD_BITS-1:0]    q_pay,
  output logic signed [PRIORITY_BITS-1:0]  q_pri
);

  logic        [PAYLOAD_BITS-1:0]  pay_r, pay_nxt;
  logic signed [PRIORITY_BITS-1:0] pri_r, pri_nxt;

  // new entry goes at or before this slot when the slot is free or holds a larger priority
  assign gt = !occupied || (pri_r > new_pri);

  // slot update: the first slot that is free or holds a larger priority takes the new entry, later ones shift up
  always_comb begin
    pay_nxt = pay_r;
    pri_nxt = pri_r;
    if (ctrl.enq && gt) begin
      if (gt_prev) begin
        pay_nxt = prev_pay;
        pri_nxt = prev_pri;
      end else begin
        pay_nxt = new_pay;
        pri_nxt = new_pri;
      end
    end else if (ctrl.deq) begin
      pay_nxt = next_pay;
      pri_nxt = next_pri;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
    pri_r <= pri_nxt;
  end

  assign q_pay = pay_r;
  assign q_pri = pri_r;

endmodule

`default_nettype wire

// ===== tb/sv/sorted_priority_queue_top_tb.sv =====
// self-checking testbench for the sorted priority queue top level
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

  localparam int CAPACITY      = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int MAX_REPORTS   = 10;

  // one predicted result transaction
  typedef struct {
    spq_pkg::status_t                 status;
    logic        [PAYLOAD_BITS-1:0]   deq_payload;
    logic signed [PRIORITY_BITS-1:0]  deq_priority;
    logic        [CNT_W-1:0]          count;
    logic                             empty;
    logic        [PAYLOAD_BITS-1:0]   head_payload;
    logic signed [PRIORITY_BITS-1:0]  head_priority;
    logic        [PAYLOAD_BITS-1:0]   tail_payload;
    logic signed [PRIORITY_BITS-1:0]  tail_priority;
  } queue_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_op;
  logic        [PAYLOAD_BITS-1:0]   in_item_payload;
  logic signed [PRIORITY_BITS-1:0]  in_item_priority;
  logic                             out_valid;
  logic                             out_stall;
  logic        [1:0]                out_status;
  logic        [PAYLOAD_BITS-1:0]   out_payload;
  logic signed [PRIORITY_BITS-1:0]  out_priority;
  logic        [CNT_W-1:0]          out_entry_count;
  logic                             out_is_empty;
  logic        [PAYLOAD_BITS-1:0]   out_head_payload;
  logic signed [PRIORITY_BITS-1:0]  out_head_priority;
  logic        [PAYLOAD_BITS-1:0]   out_tail_payload;
  logic signed [PRIORITY_BITS-1:0]  out_tail_priority;

  // shadow copy of the sorted slots
  logic        [PAYLOAD_BITS-1:0]   shadow_payload  [CAPACITY];
  logic signed [PRIORITY_BITS-1:0]  shadow_priority [CAPACITY];
  int                               shadow_count;

  queue_result_t                    pending_results[$];
  int                               mismatch_count;
  bit                               tx_idle_on;
  bit                               rx_idle_on;
  int                               rx_hold_cycles;

  sorted_priority_queue_top #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_item_payload   (in_item_payload),
    .in_item_priority  (in_item_priority),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_payload       (out_payload),
    .out_priority      (out_priority),
    .out_entry_count   (out_entry_count),
    .out_is_empty      (out_is_empty),
    .out_head_payload  (out_head_payload),
    .out_head_priority (out_head_priority),
    .out_tail_payload  (out_tail_payload),
    .out_tail_priority (out_tail_priority)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("sorted_priority_queue_top regression: fail");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // priority mix: small range for ties, full range, and the extremes
  function automatic logic signed [PRIORITY_BITS-1:0] pick_priority();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      v = int'($urandom_range(0, 8)) - 4;
      return v[PRIORITY_BITS-1:0];
    end
    if (r < 8) return PRIORITY_BITS'($urandom);
    return r[0] ? 16'sh7fff : 16'sh8000;
  endfunction

  // sorted insert or head removal on the shadow slots, returns the expected result
  function automatic queue_result_t predict_step(input logic op,
                                                 input logic [PAYLOAD_BITS-1:0] pay,
                                                 input logic signed [PRIORITY_BITS-1:0] pri);
    queue_result_t r;
    int pos;
    int i;
    r.status       = spq_pkg::ST_OK;
    r.deq_payload  = '0;
    r.deq_priority = '0;
    if (op == spq_pkg::OP_ENQUEUE) begin
      if (shadow_count >= CAPACITY) begin
        r.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // equal priorities go behind the stored ones
        pos = 0;
        while (pos < shadow_count && shadow_priority[pos] <= pri) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_payload[i]  = shadow_payload[i-1];
          shadow_priority[i] = shadow_priority[i-1];
        end
        shadow_payload[pos]  = pay;
        shadow_priority[pos] = pri;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::ST_UNDERFLOW;
      end else begin
        r.deq_payload  = shadow_payload[0];
        r.deq_priority = shadow_priority[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_payload[i-1]  = shadow_payload[i];
          shadow_priority[i-1] = shadow_priority[i];
        end
        shadow_count--;
      end
    end
    r.count = CNT_W'(shadow_count);
    r.empty = (shadow_count == 0);
    if (shadow_count == 0) begin
      r.head_payload  = '0;
      r.head_priority = '0;
      r.tail_payload  = '0;
      r.tail_priority = '0;
    end else begin
      r.head_payload  = shadow_payload[0];
      r.head_priority = shadow_priority[0];
      r.tail_payload  = shadow_payload[shadow_count-1];
      r.tail_priority = shadow_priority[shadow_count-1];
    end
    return r;
  endfunction

  // send one input transaction, then an optional sender gap
  task automatic send_item(input logic op, input logic [PAYLOAD_BITS-1:0] pay,
                           input logic signed [PRIORITY_BITS-1:0] pri);
    int gap;
    @(negedge clk);
    in_valid         = 1'b1;
    in_op            = op;
    in_item_payload  = pay;
    in_item_priority = pri;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_step(op, pay, pri));
    if (tx_idle_on) begin
      gap = idle_len();
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // random enqueue or dequeue with the given enqueue share
  task automatic send_random(input int enq_pct);
    logic op;
    op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQUEUE : spq_pkg::OP_DEQUEUE;
    send_item(op, $urandom, pick_priority());
  endtask

  // sender pauses until every pending result has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch %s: expected %h actual %h at %0t", name, want, got, $realtime);
    end
  endtask

  // result checker
  initial begin
    queue_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result transaction with nothing pending at %0t", $realtime);
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("payload", want.deq_payload, out_payload);
          check_field("priority", want.deq_priority, out_priority);
          check_field("entry_count", want.count, out_entry_count);
          check_field("is_empty", want.empty, out_is_empty);
          check_field("head_payload", want.head_payload, out_head_payload);
          check_field("head_priority", want.head_priority, out_head_priority);
          check_field("tail_payload", want.tail_payload, out_tail_payload);
          check_field("tail_priority", want.tail_priority, out_tail_priority);
        end
      end
    end
  end

  // receiver: long hold on request, otherwise random stall gaps
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall = 1'b1;
        while (rx_hold_cycles > 0) begin
          @(negedge clk);
          rx_hold_cycles--;
        end
        out_stall = 1'b0;
      end else if (rx_idle_on) begin
        gap = idle_len();
        if (gap > 0) begin
          out_stall = 1'b1;
          repeat (gap) @(negedge clk);
        end
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // field extremes, ties, ignored dequeue fields, underflow
  task automatic test_directed_extremes();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_item(spq_pkg::OP_DEQUEUE, 32'hffff_ffff, 16'shffff);
    send_item(spq_pkg::OP_ENQUEUE, 32'h0000_0000, 16'sh7fff);
    send_item(spq_pkg::OP_ENQUEUE, 32'hffff_ffff, 16'sh8000);
    send_item(spq_pkg::OP_ENQUEUE, 32'h0000_0001, 16'sh0000);
    send_item(spq_pkg::OP_ENQUEUE, 32'h0000_0002, 16'sh0000);
    send_item(spq_pkg::OP_ENQUEUE, 32'h0000_0003, 16'sh0000);
    send_item(spq_pkg::OP_ENQUEUE, 32'h8000_0001, 16'shffff);
    repeat (6) send_item(spq_pkg::OP_DEQUEUE, 32'h0000_0000, 16'sh0000);
    send_item(spq_pkg::OP_DEQUEUE, 32'h5a5a_a5a5, 16'sh7fff);
  endtask

  // fill to capacity, drop on overflow, drain past empty
  task automatic test_fill_overflow();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (CAPACITY + 3) send_item(spq_pkg::OP_ENQUEUE, $urandom, pick_priority());
    repeat (CAPACITY + 2) send_item(spq_pkg::OP_DEQUEUE, $urandom, pick_priority());
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_output_backpressure();
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 80;
    repeat (40) send_random(70);
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (100) send_random(60);
  endtask

  // waves of enqueue-heavy, balanced and dequeue-heavy traffic
  task automatic test_random_waves();
    int wave;
    int enq_pct;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (wave = 0; wave < 17; wave++) begin
      case ($urandom_range(0, 2))
        0: begin
          enq_pct = 85;
        end
        1: begin
          enq_pct = 50;
        end
        default: begin
          enq_pct = 15;
        end
      endcase
      repeat (50) send_random(enq_pct);
    end
  endtask

  // main sequence
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = spq_pkg::OP_ENQUEUE;
    in_item_payload  = '0;
    in_item_priority = '0;
    mismatch_count   = 0;
    shadow_count     = 0;
    tx_idle_on       = 1'b0;
    rx_idle_on       = 1'b0;
    rx_hold_cycles   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_extremes();
    wait_drained();
    test_fill_overflow();
    wait_drained();
    test_output_backpressure();
    wait_drained();
    test_back_to_back();
    wait_drained();
    test_random_waves();
    wait_drained();
    repeat (5) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("sorted_priority_queue_top regression: pass");
    end else begin
      $display("sorted_priority_queue_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sorted_priority_queue_top.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
tb/sv/sorted_priority_queue_top_tb.sv
